### design/assert_macros.svh
// Assertion macros shared by the event queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ceq_pkg.sv
// Shared types, widths and codes of the coalescing event queue.
package ceq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int TYPE_W    = 8;
   localparam int TICK_W    = 32;
   localparam int DATA_W    = 64;
   localparam int MASK_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_W   = TYPE_W + TICK_W + DATA_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Command codes.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Push status codes.
   localparam logic [STATUS_W-1:0] PUSH_DROPPED = 2'd0;
   localparam logic [STATUS_W-1:0] PUSH_STORED  = 2'd1;
   localparam logic [STATUS_W-1:0] PUSH_EVICTED = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_DOORBELL   = 2'd0;
   localparam logic [1:0] REG_APPEARANCE = 2'd1;
   localparam logic [1:0] REG_POINTER    = 2'd2;
   localparam logic [1:0] REG_FOCUS      = 2'd3;

   // Register reset values.
   localparam logic [TYPE_W-1:0] DOORBELL_RESET   = 8'd1;
   localparam logic [TYPE_W-1:0] APPEARANCE_RESET = 8'd2;
   localparam logic [TYPE_W-1:0] POINTER_RESET    = 8'd3;
   localparam logic [TYPE_W-1:0] FOCUS_RESET      = 8'd4;

   // Source that a pop is served from.
   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_LOOK,
      SEL_BELL,
      SEL_RING,
      SEL_POINT
   } sel_type;

   typedef struct packed {
      logic [TYPE_W-1:0] doorbell_code;
      logic [TYPE_W-1:0] appearance_code;
      logic [TYPE_W-1:0] pointer_code;
      logic [TYPE_W-1:0] focus_code;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic ram_rd;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pop_ring;
      logic out_free;
   } ctrl_stat_type;

endpackage

### design/ceq_ram.sv
// Generic single-port-write, registered-read RAM.
module ceq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ceq_datapath.sv
// Datapath of the event queue: command latch, slots, ring indexes, ring RAM and result register.
`include "assert_macros.svh"
module ceq_datapath #(
   parameter int DEPTH = ceq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ceq_pkg::cfg_type                  cfg,
   input  ceq_pkg::ctrl_cmd_type             cmd,
   output ceq_pkg::ctrl_stat_type            stat,
   input  logic                              req_cmd,
   input  logic [ceq_pkg::TYPE_W-1:0]        req_ev_type,
   input  logic [ceq_pkg::TICK_W-1:0]        req_ev_tick,
   input  logic [ceq_pkg::DATA_W-1:0]        req_ev_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ceq_pkg::STATUS_W-1:0]      rsp_push_status,
   output logic                              rsp_pop_valid,
   output logic [ceq_pkg::TYPE_W-1:0]        rsp_out_type,
   output logic [ceq_pkg::TICK_W-1:0]        rsp_out_tick,
   output logic [ceq_pkg::DATA_W-1:0]        rsp_out_data
);

   localparam int IDX_W = $clog2(DEPTH);

   // Latched command beat.
   logic                         cmd_ff;
   logic [ceq_pkg::TYPE_W-1:0]   type_ff;
   logic [ceq_pkg::TICK_W-1:0]   tick_ff;
   logic [ceq_pkg::DATA_W-1:0]   data_ff;

   // Queue state.
   logic [IDX_W-1:0]             wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic [ceq_pkg::MASK_W-1:0]   bell_mask_ff, bell_mask_in;
   logic [ceq_pkg::TICK_W-1:0]   bell_tick_ff, bell_tick_in;
   logic                         bell_pending_ff, bell_pending_in;
   logic                         bell_yield_ff, bell_yield_in;
   logic [ceq_pkg::TICK_W-1:0]   look_tick_ff, look_tick_in;
   logic [ceq_pkg::DATA_W-1:0]   look_data_ff, look_data_in;
   logic                         look_pending_ff, look_pending_in;
   logic [ceq_pkg::TICK_W-1:0]   point_tick_ff, point_tick_in;
   logic [ceq_pkg::DATA_W-1:0]   point_data_ff, point_data_in;
   logic                         point_pending_ff, point_pending_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ceq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         pop_valid_ff, pop_valid_in;
   logic [ceq_pkg::TYPE_W-1:0]   out_type_ff, out_type_in;
   logic [ceq_pkg::TICK_W-1:0]   out_tick_ff, out_tick_in;
   logic [ceq_pkg::DATA_W-1:0]   out_data_ff, out_data_in;

   logic                         is_bell, is_look, is_point, is_ring, is_focus;
   logic                         ring_empty, ring_full;
   logic [IDX_W-1:0]             wr_next;
   logic [IDX_W-1:0]             rd_next;
   ceq_pkg::sel_type             sel;
   logic [ceq_pkg::STATUS_W-1:0] push_status;
   logic                         ring_wr;
   logic [ceq_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [ceq_pkg::ENTRY_W-1:0]  ram_rdata;
   logic                         out_free;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      advance = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // Latch the accepted command beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         type_ff <= req_ev_type;
         tick_ff <= req_ev_tick;
         data_ff <= req_ev_data;
      end
   end

   // Classify a push; the first matching code wins.
   assign is_bell  = (type_ff == cfg.doorbell_code);
   assign is_look  = !is_bell && (type_ff == cfg.appearance_code);
   assign is_point = !is_bell && !is_look && (type_ff == cfg.pointer_code);
   assign is_ring  = !is_bell && !is_look && !is_point;
   assign is_focus = (type_ff == cfg.focus_code);

   // Ring occupancy.
   assign wr_next    = advance(wr_idx_ff);
   assign rd_next    = advance(rd_idx_ff);
   assign ring_empty = (wr_idx_ff == rd_idx_ff);
   assign ring_full  = (wr_next == rd_idx_ff);

   // Pop source in priority order.
   always_comb begin
      if (look_pending_ff) begin
         sel = ceq_pkg::SEL_LOOK;
      end else if (bell_pending_ff && (!bell_yield_ff || ring_empty)) begin
         sel = ceq_pkg::SEL_BELL;
      end else if (!ring_empty) begin
         sel = ceq_pkg::SEL_RING;
      end else if (point_pending_ff) begin
         sel = ceq_pkg::SEL_POINT;
      end else begin
         sel = ceq_pkg::SEL_NONE;
      end
   end

   // Outcome of a push.
   always_comb begin
      if (!is_ring || !ring_full) begin
         push_status = ceq_pkg::PUSH_STORED;
      end else if (is_focus) begin
         push_status = ceq_pkg::PUSH_EVICTED;
      end else begin
         push_status = ceq_pkg::PUSH_DROPPED;
      end
   end

   assign ring_wr   = cmd.commit && (cmd_ff == ceq_pkg::CMD_PUSH) && is_ring &&
                      (push_status != ceq_pkg::PUSH_DROPPED);
   assign ram_wdata = {type_ff, tick_ff, data_ff};

   // Ring storage: type, tick and payload side by side.
   ceq_ram #(
      .WIDTH (ceq_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (wr_idx_ff),
      .wr_data (ram_wdata),
      .rd_en   (cmd.ram_rd),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   // Output register can take a beat when empty or being drained.
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign stat.out_free = out_free;
   assign stat.pop_ring = (cmd_ff == ceq_pkg::CMD_POP) && (sel == ceq_pkg::SEL_RING);

   // Next state and result of the latched command, applied on commit.
   always_comb begin
      wr_idx_in        = wr_idx_ff;
      rd_idx_in        = rd_idx_ff;
      bell_mask_in     = bell_mask_ff;
      bell_tick_in     = bell_tick_ff;
      bell_pending_in  = bell_pending_ff;
      bell_yield_in    = bell_yield_ff;
      look_tick_in     = look_tick_ff;
      look_data_in     = look_data_ff;
      look_pending_in  = look_pending_ff;
      point_tick_in    = point_tick_ff;
      point_data_in    = point_data_ff;
      point_pending_in = point_pending_ff;
      status_in        = ceq_pkg::PUSH_DROPPED;
      pop_valid_in     = 1'b0;
      out_type_in      = '0;
      out_tick_in      = '0;
      out_data_in      = '0;
      if (cmd_ff == ceq_pkg::CMD_PUSH) begin
         status_in = push_status;
         if (is_bell) begin
            bell_mask_in    = bell_mask_ff | data_ff[ceq_pkg::MASK_W-1:0];
            bell_tick_in    = tick_ff;
            bell_pending_in = 1'b1;
         end else if (is_look) begin
            look_tick_in    = tick_ff;
            look_data_in    = data_ff;
            look_pending_in = 1'b1;
         end else if (is_point) begin
            point_tick_in    = tick_ff;
            point_data_in    = data_ff;
            point_pending_in = 1'b1;
         end else if (push_status != ceq_pkg::PUSH_DROPPED) begin
            wr_idx_in = wr_next;
            if (push_status == ceq_pkg::PUSH_EVICTED) begin
               rd_idx_in = rd_next;
            end
         end
      end else begin
         case (sel)
            ceq_pkg::SEL_LOOK: begin
               pop_valid_in    = 1'b1;
               out_type_in     = cfg.appearance_code;
               out_tick_in     = look_tick_ff;
               out_data_in     = look_data_ff;
               look_pending_in = 1'b0;
            end
            ceq_pkg::SEL_BELL: begin
               pop_valid_in    = 1'b1;
               out_type_in     = cfg.doorbell_code;
               out_tick_in     = bell_tick_ff;
               out_data_in     = {{(ceq_pkg::DATA_W - ceq_pkg::MASK_W){1'b0}}, bell_mask_ff};
               bell_mask_in    = '0;
               bell_pending_in = 1'b0;
               bell_yield_in   = 1'b1;
            end
            ceq_pkg::SEL_RING: begin
               pop_valid_in  = 1'b1;
               out_type_in   = ram_rdata[ceq_pkg::ENTRY_W-1 -: ceq_pkg::TYPE_W];
               out_tick_in   = ram_rdata[ceq_pkg::DATA_W +: ceq_pkg::TICK_W];
               out_data_in   = ram_rdata[ceq_pkg::DATA_W-1:0];
               rd_idx_in     = rd_next;
               bell_yield_in = 1'b0;
            end
            ceq_pkg::SEL_POINT: begin
               pop_valid_in     = 1'b1;
               out_type_in      = cfg.pointer_code;
               out_tick_in      = point_tick_ff;
               out_data_in      = point_data_ff;
               point_pending_in = 1'b0;
            end
            default: begin
               pop_valid_in = 1'b0;
            end
         endcase
      end
   end

   // Result beat handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff        <= '0;
         rd_idx_ff        <= '0;
         bell_mask_ff     <= '0;
         bell_pending_ff  <= 1'b0;
         bell_yield_ff    <= 1'b0;
         look_pending_ff  <= 1'b0;
         point_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            wr_idx_ff        <= wr_idx_in;
            rd_idx_ff        <= rd_idx_in;
            bell_mask_ff     <= bell_mask_in;
            bell_pending_ff  <= bell_pending_in;
            bell_yield_ff    <= bell_yield_in;
            look_pending_ff  <= look_pending_in;
            point_pending_ff <= point_pending_in;
         end
      end
   end

   // Slot payloads and the result beat.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         bell_tick_ff  <= bell_tick_in;
         look_tick_ff  <= look_tick_in;
         look_data_ff  <= look_data_in;
         point_tick_ff <= point_tick_in;
         point_data_ff <= point_data_in;
         status_ff     <= status_in;
         pop_valid_ff  <= pop_valid_in;
         out_type_ff   <= out_type_in;
         out_tick_ff   <= out_tick_in;
         out_data_ff   <= out_data_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_push_status = status_ff;
   assign rsp_pop_valid   = pop_valid_ff;
   assign rsp_out_type    = out_type_ff;
   assign rsp_out_tick    = out_tick_ff;
   assign rsp_out_data    = out_data_ff;

   // A commit never overwrites a result that has not been taken.
   `ASSERT_IMPLY(a_commit_free, clock, reset, cmd.commit, out_free, "commit over a held result")
   // Serving the ring head always moves the read index.
   `ASSERT_NEXT(a_ring_pop_moves, clock, reset, cmd.commit && stat.pop_ring, rd_idx_ff != $past(rd_idx_ff), "ring pop left read index")
   // The doorbell mask is clear whenever no doorbell is pending.
   `ASSERT_ALWAYS(a_mask_idle, clock, reset, bell_pending_ff || (bell_mask_ff == '0), "mask set without pending doorbell")

endmodule

### design/ceq_ctrl.sv
// Sequencer of the event queue: accepts a command, schedules the ring read and the commit.
`include "assert_macros.svh"
module ceq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ceq_pkg::ctrl_stat_type stat,
   output ceq_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0] state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.ram_rd  = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.pop_ring) begin
               cmd.ram_rd = 1'b1;
               state_in   = ST_READ;
            end else if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // The read wait only follows execution of a ring pop.
   `ASSERT_IMPLY(a_read_entry, clock, reset, state_ff == ST_READ, $past(state_ff) == ST_EXEC || $past(state_ff) == ST_READ, "read wait entered out of order")

endmodule

### design/coalescing_event_queue.sv
// Top level of the coalescing event queue: register block, sequencer and datapath.
// A push or a slot pop is latched on acceptance and then committed into the result
// register; a pop served from the ring first waits in the read state, set by the
// registered read of the ring RAM. A commit waits while a result beat is stalled;
// the sequencer takes the next beat only once the previous one has been committed.
// Reset clears indexes, pending flags, the doorbell mask and the registers to their
// default codes at once; the ring RAM needs no clearing pass.
module coalescing_event_queue #(
   parameter int DEPTH = ceq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [ceq_pkg::TYPE_W-1:0]        req_ev_type,
   input  logic [ceq_pkg::TICK_W-1:0]        req_ev_tick,
   input  logic [ceq_pkg::DATA_W-1:0]        req_ev_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ceq_pkg::STATUS_W-1:0]      rsp_push_status,
   output logic                              rsp_pop_valid,
   output logic [ceq_pkg::TYPE_W-1:0]        rsp_out_type,
   output logic [ceq_pkg::TICK_W-1:0]        rsp_out_tick,
   output logic [ceq_pkg::DATA_W-1:0]        rsp_out_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ceq_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ceq_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ceq_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   ceq_pkg::cfg_type       cfg_ff;
   ceq_pkg::ctrl_cmd_type  cmd;
   ceq_pkg::ctrl_stat_type stat;
   logic                   csr_wr;
   logic [1:0]             csr_idx;
   logic [ceq_pkg::TYPE_W-1:0] csr_rval;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   // Type code registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.doorbell_code   <= ceq_pkg::DOORBELL_RESET;
         cfg_ff.appearance_code <= ceq_pkg::APPEARANCE_RESET;
         cfg_ff.pointer_code    <= ceq_pkg::POINTER_RESET;
         cfg_ff.focus_code      <= ceq_pkg::FOCUS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ceq_pkg::REG_DOORBELL:   cfg_ff.doorbell_code   <= pwdata[ceq_pkg::TYPE_W-1:0];
            ceq_pkg::REG_APPEARANCE: cfg_ff.appearance_code <= pwdata[ceq_pkg::TYPE_W-1:0];
            ceq_pkg::REG_POINTER:    cfg_ff.pointer_code    <= pwdata[ceq_pkg::TYPE_W-1:0];
            ceq_pkg::REG_FOCUS:      cfg_ff.focus_code      <= pwdata[ceq_pkg::TYPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_idx)
         ceq_pkg::REG_DOORBELL:   csr_rval = cfg_ff.doorbell_code;
         ceq_pkg::REG_APPEARANCE: csr_rval = cfg_ff.appearance_code;
         ceq_pkg::REG_POINTER:    csr_rval = cfg_ff.pointer_code;
         ceq_pkg::REG_FOCUS:      csr_rval = cfg_ff.focus_code;
         default:                 csr_rval = '0;
      endcase
   end

   assign prdata = {{(ceq_pkg::CSR_DATA_W - ceq_pkg::TYPE_W){1'b0}}, csr_rval};

   ceq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ceq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_ev_type     (req_ev_type),
      .req_ev_tick     (req_ev_tick),
      .req_ev_data     (req_ev_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_push_status (rsp_push_status),
      .rsp_pop_valid   (rsp_pop_valid),
      .rsp_out_type    (rsp_out_type),
      .rsp_out_tick    (rsp_out_tick),
      .rsp_out_data    (rsp_out_data)
   );

endmodule
